/* rtl/core/csrp_pkg.sv */
// csrp_pkg: shared types and constants for the cache set replacement block
// used by csrp_ctrl, csrp_dp and cache_set_replacement_policy; no dependencies
package csrp_pkg;

    localparam int ADDR_W      = 32;
    localparam int CLASS_W     = 2;
    localparam int WAY_OUT_W   = 3;
    localparam int POLICY_W    = 2;
    localparam int OFFSET_W    = 4;
    localparam int CFG_DATA_W  = 4;
    localparam int CFG_INDEX_W = 1;

    // replacement policy codes, code 3 acts as lru
    localparam logic [POLICY_W-1:0] POL_LFU  = 2'd0;
    localparam logic [POLICY_W-1:0] POL_FIFO = 2'd1;
    localparam logic [POLICY_W-1:0] POL_LRU  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_POLICY_MODE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_OFFSET = 1'b1;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 4'd6;

    // operation codes
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_FILL   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
    } dp_status_t;

endpackage

/* rtl/core/csrp_ctrl.sv */
// csrp_ctrl: sequencer for one word, idle -> scan over all ways -> commit
// depends on csrp_pkg
module csrp_ctrl
    import csrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output logic       busy,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/csrp_dp.sv */
// csrp_dp: way storage, configuration registers, scan accumulators and result registers
// depends on csrp_pkg; driven by csrp_ctrl commands
module csrp_dp
    import csrp_pkg::*;
#(
    parameter int WAYS       = 8,
    parameter int COUNT_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   op,
    input  logic [ADDR_W-1:0]      address,
    input  logic [CLASS_W-1:0]     priority_req,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    output logic                   done,
    output logic [WAY_OUT_W-1:0]   way,
    output logic                   hit,
    output logic                   evicted_valid,
    output logic [ADDR_W-1:0]      evicted_address,
    output logic [CLASS_W-1:0]     evicted_priority
);

    localparam int WAY_W = $clog2(WAYS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // configuration
    logic [POLICY_W-1:0] policy_reg, policy_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;

    // way storage
    logic                  valid_reg      [WAYS];
    logic                  valid_next     [WAYS];
    logic [COUNT_BITS-1:0] count_reg      [WAYS];
    logic [COUNT_BITS-1:0] count_next     [WAYS];
    logic [ADDR_W-1:0]     line_base_reg  [WAYS];
    logic [ADDR_W-1:0]     line_base_next [WAYS];
    logic [CLASS_W-1:0]    line_class_reg [WAYS];
    logic [CLASS_W-1:0]    line_class_next[WAYS];

    // latched request
    logic               op_reg, op_next;
    logic [ADDR_W-1:0]  req_base_reg, req_base_next;
    logic [CLASS_W-1:0] req_class_reg, req_class_next;

    // scan accumulators
    logic [WAY_W-1:0]      idx_reg, idx_next;
    logic [COUNT_BITS-1:0] top_reg, top_next;
    logic                  hit_found_reg, hit_found_next;
    logic [WAY_W-1:0]      hit_way_reg, hit_way_next;
    logic                  free_found_reg, free_found_next;
    logic [WAY_W-1:0]      free_way_reg, free_way_next;
    logic                  vic_found_reg, vic_found_next;
    logic [WAY_W-1:0]      vic_way_reg, vic_way_next;
    logic [COUNT_BITS-1:0] vic_count_reg, vic_count_next;
    logic [ADDR_W-1:0]     vic_base_reg, vic_base_next;
    logic [CLASS_W-1:0]    vic_class_reg, vic_class_next;

    // result registers
    logic                 done_reg, done_next;
    logic [WAY_OUT_W-1:0] way_reg, way_next;
    logic                 hit_reg, hit_next;
    logic                 ev_valid_reg, ev_valid_next;
    logic [ADDR_W-1:0]    ev_addr_reg, ev_addr_next;
    logic [CLASS_W-1:0]   ev_class_reg, ev_class_next;

    // combinational helpers
    logic [ADDR_W-1:0]       align_mask;
    logic                    cur_valid;
    logic [COUNT_BITS-1:0]   cur_count;
    logic [ADDR_W-1:0]       cur_base;
    logic [CLASS_W-1:0]      cur_class;
    logic                    is_fifo;
    logic                    is_lfu;
    logic                    vic_better;
    logic [COUNT_BITS-1:0]   top_inc;
    logic [WAY_W-1:0]        fill_way;
    logic [WAY_W-1:0]        report_way;
    logic [WAY_W+WAY_OUT_W-1:0] report_ext;
    logic                    match;

    assign align_mask = ~((ADDR_W'(1) << offset_reg) - ADDR_W'(1));
    assign cur_valid  = valid_reg[idx_reg];
    assign cur_count  = count_reg[idx_reg];
    assign cur_base   = line_base_reg[idx_reg];
    assign cur_class  = line_class_reg[idx_reg];
    assign is_fifo    = (policy_reg == POL_FIFO);
    assign is_lfu     = (policy_reg == POL_LFU);
    assign vic_better = !vic_found_reg ||
                        (is_fifo ? (cur_count > vic_count_reg) : (cur_count < vic_count_reg));
    assign top_inc    = (top_reg == COUNT_MAX) ? COUNT_MAX : top_reg + COUNT_BITS'(1);
    assign fill_way   = free_found_reg ? free_way_reg :
                        (vic_found_reg ? vic_way_reg : '0);
    assign report_way = (op_reg == OP_FILL) ? fill_way : (hit_found_reg ? hit_way_reg : '0);
    // way number reported modulo eight
    assign report_ext = {{WAY_OUT_W{1'b0}}, report_way};

    assign status.scan_last = (idx_reg == WAY_W'(WAYS - 1));

    assign done             = done_reg;
    assign way              = way_reg;
    assign hit              = hit_reg;
    assign evicted_valid    = ev_valid_reg;
    assign evicted_address  = ev_addr_reg;
    assign evicted_priority = ev_class_reg;

    // configuration writes
    always_comb
    begin
        policy_next = policy_reg;
        offset_next = offset_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_POLICY_MODE: policy_next = cfg_data[POLICY_W-1:0];
                REG_LINE_OFFSET: offset_next = cfg_data;
                default:         ;
            endcase
        end
    end

    // request latch and scan accumulators
    always_comb
    begin
        op_next         = op_reg;
        req_base_next   = req_base_reg;
        req_class_next  = req_class_reg;
        idx_next        = idx_reg;
        top_next        = top_reg;
        hit_found_next  = hit_found_reg;
        hit_way_next    = hit_way_reg;
        free_found_next = free_found_reg;
        free_way_next   = free_way_reg;
        vic_found_next  = vic_found_reg;
        vic_way_next    = vic_way_reg;
        vic_count_next  = vic_count_reg;
        vic_base_next   = vic_base_reg;
        vic_class_next  = vic_class_reg;
        if (cmd.load)
        begin
            op_next         = op;
            req_base_next   = address & align_mask;
            req_class_next  = priority_req;
            idx_next        = '0;
            top_next        = '0;
            hit_found_next  = 1'b0;
            hit_way_next    = '0;
            free_found_next = 1'b0;
            free_way_next   = '0;
            vic_found_next  = 1'b0;
            vic_way_next    = '0;
            vic_count_next  = '0;
        end
        else if (cmd.scan)
        begin
            idx_next = idx_reg + WAY_W'(1);
            if (cur_valid && (cur_count > top_reg))
            begin
                top_next = cur_count;
            end
            if (cur_valid && (cur_base == req_base_reg) && !hit_found_reg)
            begin
                hit_found_next = 1'b1;
                hit_way_next   = idx_reg;
            end
            if (!cur_valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_way_next   = idx_reg;
            end
            // victim candidate within the requested class, ties keep the lower way
            if ((cur_class == req_class_reg) && vic_better)
            begin
                vic_found_next = 1'b1;
                vic_way_next   = idx_reg;
                vic_count_next = cur_count;
                vic_base_next  = cur_base;
                vic_class_next = cur_class;
            end
        end
    end

    // way storage update and result capture
    always_comb
    begin
        match         = 1'b0;
        done_next     = cmd.commit;
        way_next      = way_reg;
        hit_next      = hit_reg;
        ev_valid_next = ev_valid_reg;
        ev_addr_next  = ev_addr_reg;
        ev_class_next = ev_class_reg;
        for (int i = 0; i < WAYS; i++)
        begin
            valid_next[i]      = valid_reg[i];
            count_next[i]      = count_reg[i];
            line_base_next[i]  = line_base_reg[i];
            line_class_next[i] = line_class_reg[i];
        end
        if (cmd.commit)
        begin
            way_next = report_ext[WAY_OUT_W-1:0];
            if (op_reg == OP_ACCESS)
            begin
                hit_next      = hit_found_reg;
                ev_valid_next = 1'b0;
                ev_addr_next  = '0;
                ev_class_next = '0;
                for (int i = 0; i < WAYS; i++)
                begin
                    match = valid_reg[i] && (line_base_reg[i] == req_base_reg);
                    if (is_fifo)
                    begin
                        if (valid_reg[i] && (count_reg[i] != COUNT_MAX))
                        begin
                            count_next[i] = count_reg[i] + COUNT_BITS'(1);
                        end
                    end
                    else if (match)
                    begin
                        if (is_lfu)
                        begin
                            if (count_reg[i] != COUNT_MAX)
                            begin
                                count_next[i] = count_reg[i] + COUNT_BITS'(1);
                            end
                        end
                        else
                        begin
                            count_next[i] = top_inc;
                        end
                    end
                end
            end
            else
            begin
                hit_next      = 1'b0;
                ev_valid_next = !free_found_reg;
                if (free_found_reg)
                begin
                    ev_addr_next  = '0;
                    ev_class_next = '0;
                end
                else if (vic_found_reg)
                begin
                    ev_addr_next  = vic_base_reg;
                    ev_class_next = vic_class_reg;
                end
                else
                begin
                    ev_addr_next  = line_base_reg[0];
                    ev_class_next = line_class_reg[0];
                end
                valid_next[fill_way]      = 1'b1;
                count_next[fill_way]      = '0;
                line_base_next[fill_way]  = req_base_reg;
                line_class_next[fill_way] = req_class_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_LRU;
            offset_reg <= OFFSET_RESET;
            done_reg   <= 1'b0;
            for (int i = 0; i < WAYS; i++)
            begin
                valid_reg[i] <= 1'b0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            policy_reg <= policy_next;
            offset_reg <= offset_next;
            done_reg   <= done_next;
            for (int i = 0; i < WAYS; i++)
            begin
                valid_reg[i] <= valid_next[i];
                count_reg[i] <= count_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        req_base_reg   <= req_base_next;
        req_class_reg  <= req_class_next;
        idx_reg        <= idx_next;
        top_reg        <= top_next;
        hit_found_reg  <= hit_found_next;
        hit_way_reg    <= hit_way_next;
        free_found_reg <= free_found_next;
        free_way_reg   <= free_way_next;
        vic_found_reg  <= vic_found_next;
        vic_way_reg    <= vic_way_next;
        vic_count_reg  <= vic_count_next;
        vic_base_reg   <= vic_base_next;
        vic_class_reg  <= vic_class_next;
        way_reg        <= way_next;
        hit_reg        <= hit_next;
        ev_valid_reg   <= ev_valid_next;
        ev_addr_reg    <= ev_addr_next;
        ev_class_reg   <= ev_class_next;
        for (int i = 0; i < WAYS; i++)
        begin
            line_base_reg[i]  <= line_base_next[i];
            line_class_reg[i] <= line_class_next[i];
        end
    end

endmodule

/* rtl/core/cache_set_replacement_policy.sv */
// cache_set_replacement_policy: top level of one cache set with lfu, fifo and lru replacement
// depends on csrp_pkg, csrp_ctrl and csrp_dp
//
//   channel   handshake              payload
//   -------   ---------------------  ---------------------------------------------------
//   cfg       cfg_we                 cfg_index, cfg_data
//   request   start, busy            op, address, priority_req
//   result    done (one-cycle)       way, hit, evicted_valid, evicted_address,
//                                    evicted_priority
//
// a word is taken when start is high and busy is low; busy then stays high through
// the scan, one way at a time through a single shared compare unit, and the commit, with
// the result strobe in the cycle after commit, while busy is already low again
// a further word is taken no earlier than the cycle in which done is high
// reset clears the valid bits and use counters at once; there is no clearing pass
// the receiver cannot stall: done is high for exactly one cycle with the result fields
module cache_set_replacement_policy
    import csrp_pkg::*;
#(
    parameter int WAYS       = 8,
    parameter int COUNT_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // request word
    input  logic                   start,
    output logic                   busy,
    input  logic                   op,
    input  logic [ADDR_W-1:0]      address,
    input  logic [CLASS_W-1:0]     priority_req,
    // result word
    output logic                   done,
    output logic [WAY_OUT_W-1:0]   way,
    output logic                   hit,
    output logic                   evicted_valid,
    output logic [ADDR_W-1:0]      evicted_address,
    output logic [CLASS_W-1:0]     evicted_priority
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: load the request, walk the ways, then commit the update
    csrp_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    // way storage, per-way scan and the update of the use counters at commit
    csrp_dp #(
        .WAYS       (WAYS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .op               (op),
        .address          (address),
        .priority_req     (priority_req),
        .cmd              (cmd),
        .status           (status),
        .done             (done),
        .way              (way),
        .hit              (hit),
        .evicted_valid    (evicted_valid),
        .evicted_address  (evicted_address),
        .evicted_priority (evicted_priority)
    );

endmodule

/* sim/cache_set_replacement_policy_tb.sv */
// cache_set_replacement_policy_tb: checks one cache set against a local model of lfu, fifo and lru
// replacement, with random gaps on the request side; depends on csrp_pkg and the rtl top level
`timescale 1ns / 100ps

module cache_set_replacement_policy_tb;
    import csrp_pkg::*;

    localparam int SET_WAYS = 8;
    localparam int CNT_W    = 16;

    // unused policy code, the set treats it as lru
    localparam logic [POLICY_W-1:0] POL_SPARE = 2'd3;

    // one request word and the result word it causes
    typedef struct packed {
        logic               op;
        logic [ADDR_W-1:0]  addr;
        logic [CLASS_W-1:0] cls;
    } set_word_t;

    typedef struct packed {
        logic [WAY_OUT_W-1:0] way;
        logic                 hit;
        logic                 ev_valid;
        logic [ADDR_W-1:0]    ev_addr;
        logic [CLASS_W-1:0]   ev_cls;
    } set_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_POLICY_MODE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic start = 1'b0;
    logic busy;
    logic op = OP_ACCESS;
    logic [ADDR_W-1:0] address = '0;
    logic [CLASS_W-1:0] priority_req = '0;
    logic done;
    logic [WAY_OUT_W-1:0] way;
    logic hit;
    logic evicted_valid;
    logic [ADDR_W-1:0] evicted_address;
    logic [CLASS_W-1:0] evicted_priority;

    // words waiting to be sent, and the results the set owes us, oldest first
    set_word_t request_words[$];
    set_report_t way_reports_due[$];
    set_word_t on_port;
    set_report_t got_report;
    set_report_t due_report;
    logic go;
    logic steady = 1'b0;
    int mismatch_count = 0;

    // local copy of the set: registers and per-way line state
    logic [POLICY_W-1:0] mdl_policy;
    logic [OFFSET_W-1:0] mdl_offset;
    logic mdl_valid [SET_WAYS];
    logic [CNT_W-1:0] mdl_count [SET_WAYS];
    logic [ADDR_W-1:0] mdl_base [SET_WAYS];
    logic [CLASS_W-1:0] mdl_class [SET_WAYS];

    cache_set_replacement_policy #(
        .WAYS       (SET_WAYS),
        .COUNT_BITS (CNT_W)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .start            (start),
        .busy             (busy),
        .op               (op),
        .address          (address),
        .priority_req     (priority_req),
        .done             (done),
        .way              (way),
        .hit              (hit),
        .evicted_valid    (evicted_valid),
        .evicted_address  (evicted_address),
        .evicted_priority (evicted_priority)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // counters stick at all ones
    function automatic logic [CNT_W-1:0] sat_bump(logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

    // apply one word to the local set and return the result it must produce
    function automatic set_report_t set_model_step(set_word_t w);
        set_report_t r;
        logic [ADDR_W-1:0] base_addr;
        logic [CNT_W-1:0] top;
        logic match;
        logic found;
        int slot;
        r = '0;
        top = '0;
        found = 1'b0;
        slot = 0;
        base_addr = w.addr & ~((32'd1 << mdl_offset) - 32'd1);
        if (w.op == OP_ACCESS)
        begin
            // largest count among valid lines, taken before any update
            for (int i = 0; i < SET_WAYS; i++)
                if (mdl_valid[i] && mdl_count[i] > top)
                    top = mdl_count[i];
            for (int i = 0; i < SET_WAYS; i++)
            begin
                match = mdl_valid[i] && (mdl_base[i] == base_addr);
                // lowest matching way is reported, every match is updated
                if (match && !r.hit)
                begin
                    r.hit = 1'b1;
                    slot = i;
                end
                if (mdl_policy == POL_FIFO)
                begin
                    if (mdl_valid[i])
                        mdl_count[i] = sat_bump(mdl_count[i]);
                end
                else if (match)
                begin
                    if (mdl_policy == POL_LFU)
                        mdl_count[i] = sat_bump(mdl_count[i]);
                    else
                        mdl_count[i] = sat_bump(top);  // lru, and code 3 acts as lru
                end
            end
        end
        else
        begin
            for (int i = 0; i < SET_WAYS; i++)
                if (!found && !mdl_valid[i])
                begin
                    slot = i;
                    found = 1'b1;
                end
            if (!found)
            begin
                // victim within the requested class; none of that class leaves way 0
                for (int i = 0; i < SET_WAYS; i++)
                begin
                    if (mdl_class[i] != w.cls)
                        continue;
                    if (!found)
                    begin
                        slot = i;
                        found = 1'b1;
                    end
                    else if (mdl_policy == POL_FIFO)
                    begin
                        if (mdl_count[i] > mdl_count[slot])
                            slot = i;
                    end
                    else if (mdl_count[i] < mdl_count[slot])
                        slot = i;
                end
                r.ev_valid = 1'b1;
                r.ev_addr = mdl_base[slot];
                r.ev_cls = mdl_class[slot];
            end
            mdl_valid[slot] = 1'b1;
            mdl_count[slot] = '0;
            mdl_base[slot] = base_addr;
            mdl_class[slot] = w.cls;
        end
        r.way = slot[WAY_OUT_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
        $display("%0t mismatch on %s: got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // driver: a word is taken when start is high and busy low; start is held high until then,
    // and a ready next word follows at once in steady phases, otherwise after random idle gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            op <= OP_ACCESS;
            address <= '0;
            priority_req <= '0;
        end
        else
        begin
            go = start;
            if (start && !busy)
            begin
                way_reports_due.push_back(set_model_step(on_port));
                go = 1'b0;
            end
            if (!go && request_words.size() != 0 && (steady || $urandom_range(99) >= 38))
            begin
                on_port = request_words.pop_front();
                op <= on_port.op;
                address <= on_port.addr;
                priority_req <= on_port.cls;
                go = 1'b1;
            end
            start <= go;
        end
    end

    // monitor: done marks a one-cycle result word, matched against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            got_report = '{way, hit, evicted_valid, evicted_address, evicted_priority};
            if (way_reports_due.size() == 0)
                flag_mismatch("unexpected result word way", ADDR_W'(got_report.way), '0);
            else
            begin
                due_report = way_reports_due.pop_front();
                if (got_report.way != due_report.way)
                    flag_mismatch("way", ADDR_W'(got_report.way), ADDR_W'(due_report.way));
                if (got_report.hit != due_report.hit)
                    flag_mismatch("hit", ADDR_W'(got_report.hit), ADDR_W'(due_report.hit));
                if (got_report.ev_valid != due_report.ev_valid)
                    flag_mismatch("evicted_valid", ADDR_W'(got_report.ev_valid),
                                  ADDR_W'(due_report.ev_valid));
                if (got_report.ev_addr != due_report.ev_addr)
                    flag_mismatch("evicted_address", got_report.ev_addr, due_report.ev_addr);
                if (got_report.ev_cls != due_report.ev_cls)
                    flag_mismatch("evicted_priority", ADDR_W'(got_report.ev_cls),
                                  ADDR_W'(due_report.ev_cls));
            end
        end
    end

    task automatic add_word(logic o, logic [ADDR_W-1:0] a, logic [CLASS_W-1:0] c);
        request_words.push_back('{o, a, c});
    endtask

    // sender holds off until every word has been sent and its result has come back
    task automatic drain_set();
        while (request_words.size() != 0 || start || way_reports_due.size() != 0)
            @(negedge clk);
        repeat (SET_WAYS + 4) @(negedge clk);
    endtask

    // config writes must land only while the set is idle; the caller drains first, this task does not check
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_POLICY_MODE)
            mdl_policy = val[POLICY_W-1:0];
        else
            mdl_offset = val[OFFSET_W-1:0];
    endtask

    // one random phase: mostly accesses and fills drawn from a small pool of lines so
    // that hits, duplicates and evictions are common, plus some fully random noise
    task automatic run_phase(logic [POLICY_W-1:0] pol, logic [OFFSET_W-1:0] off,
                             logic no_gaps, int n_words);
        logic [ADDR_W-1:0] pool [10];
        logic [ADDR_W-1:0] low_mask;
        int pick;
        drain_set();
        write_reg(REG_POLICY_MODE, CFG_DATA_W'(pol));
        write_reg(REG_LINE_OFFSET, off);
        @(negedge clk);
        steady = no_gaps;
        low_mask = (32'd1 << mdl_offset) - 32'd1;
        foreach (pool[k])
            pool[k] = $urandom();
        for (int n = 0; n < n_words; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                add_word(OP_ACCESS, pool[$urandom_range(9)] ^ ($urandom() & low_mask),
                         CLASS_W'($urandom_range(3)));
            else if (pick < 90)
                add_word(OP_FILL, pool[$urandom_range(9)], CLASS_W'($urandom_range(3)));
            else
                add_word(1'($urandom_range(1)), $urandom(), CLASS_W'($urandom_range(3)));
        end
    endtask

    initial
    begin
        mdl_policy = POL_LRU;
        mdl_offset = OFFSET_RESET;
        for (int i = 0; i < SET_WAYS; i++)
        begin
            mdl_valid[i] = 1'b0;
            mdl_count[i] = '0;
            mdl_base[i] = '0;
            mdl_class[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed words under the reset setting (lru, 64-byte lines)
        add_word(OP_ACCESS, 32'h0000_1000, 2'd0);   // miss on an empty set
        add_word(OP_FILL,   32'hFFFF_FFFF, 2'd1);   // top address, lands in way 0
        add_word(OP_ACCESS, 32'hFFFF_FFC5, 2'd3);   // hit way 0 through the offset bits
        add_word(OP_FILL,   32'h0000_0000, 2'd0);
        add_word(OP_FILL,   32'h0000_0010, 2'd0);   // same line again in another way
        add_word(OP_ACCESS, 32'h0000_003F, 2'd0);   // two matches, lowest way reported
        add_word(OP_FILL,   32'h1234_5678, 2'd1);
        add_word(OP_FILL,   32'h8000_0000, 2'd2);
        add_word(OP_FILL,   32'h5555_5555, 2'd1);
        add_word(OP_FILL,   32'hAAAA_AAAA, 2'd2);
        add_word(OP_FILL,   32'h7FFF_FFC0, 2'd1);   // set now full, no class 3 line
        add_word(OP_ACCESS, 32'h1234_5640, 2'd0);
        add_word(OP_ACCESS, 32'hDEAD_BEEF, 2'd0);   // miss on a full set
        add_word(OP_FILL,   32'h0000_1234, 2'd3);   // no line of that class, way 0 goes
        add_word(OP_FILL,   32'h0BAD_F00D, 2'd0);   // victim among the class 0 lines
        add_word(OP_FILL,   32'hCAFE_0000, 2'd2);
        add_word(OP_ACCESS, 32'hFFFF_FFFF, 2'd0);
        add_word(OP_ACCESS, 32'h0000_0000, 2'd3);

        // random phases over the policies and line sizes from 1 to 4096 bytes
        run_phase(POL_LFU,   4'd0,  1'b0, 150);
        run_phase(POL_FIFO,  4'd12, 1'b0, 150);
        run_phase(POL_LRU,   4'd6,  1'b1, 150);   // no gaps on the request side
        run_phase(POL_SPARE, 4'd9,  1'b0, 150);   // unused code, acts as lru
        run_phase(POL_LFU,   4'd12, 1'b0, 150);
        run_phase(POL_FIFO,  4'd3,  1'b0, 150);
        run_phase(POL_LRU,   4'd0,  1'b0, 150);
        run_phase(POL_LFU,   4'd5,  1'b0, 150);

        drain_set();
        if (mismatch_count == 0)
            $display("cache_set_replacement_policy_tb passed");
        else
            $display("cache_set_replacement_policy_tb failed");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("cache_set_replacement_policy_tb failed");
        $finish;
    end

endmodule
